>>> design/cctc_pkg.sv
// Shared types and constants for the cascaded counter/timer byte counter.
package cctc_pkg;

    localparam int CMD_W      = 3;
    localparam int CH_W       = 2;
    localparam int NUM_CH     = 4;
    localparam int S_DATA_W   = 16;
    localparam int M_DATA_W   = 24;

    // Control word bits
    localparam logic [7:0] CW_INT_EN  = 8'h80;
    localparam logic [7:0] CW_TC_NEXT = 8'h04;
    localparam logic [7:0] CW_RESET   = 8'h02;
    localparam logic [7:0] CW_CONTROL = 8'h01;
    localparam logic [7:0] VEC_MASK   = 8'hf8;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ  = 3'd0,
        CMD_WRITE = 3'd1,
        CMD_RISE  = 3'd2,
        CMD_FALL  = 3'd3,
        CMD_TICK  = 3'd4,
        CMD_ACK   = 3'd5
    } t_cmd;

    typedef struct packed {
        logic [3:0] zero_flags;
        logic [7:0] int_vector;
        logic       int_pending;
        logic       tc_pulse;
        logic [7:0] read_data;
    } t_result;

endpackage

>>> design/cascaded_ctc_byte_counter.sv
// Top level: four-channel counter block with cascade, interrupts and output skid stage.
//
// Four-channel counter block, counter mode only. Each input word is one event:
// a bus read or write of a channel, a rise or fall of the disk controller's
// interrupt line (channel 0 trigger), a frame tick (one pulse on channel 3) or
// an interrupt acknowledge. Channel 0 reaching zero pulses channel 1, and
// channel 1 reaching zero pulses channel 2, whose zero-count rise is reported
// as tc_pulse. Every input word yields exactly one output word carrying the
// read value and the interrupt/zero-count status after the event.
// Rate: one word per clock while the skid is empty. The event is decoded and
// the channel registers are updated in the cycle it is accepted; the output
// word is registered into the output register, or into the skid when the
// sink stalls. A two-entry output (register plus skid) keeps s_axis_tready
// registered, so input is taken every cycle while the sink keeps up, and one
// more word is absorbed when the sink stalls.
module cascaded_ctc_byte_counter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // tdata: [1:0] channel, [9:2] write_data, [10] accepted, rest zero
    input  logic [cctc_pkg::S_DATA_W-1:0] s_axis_tdata,
    // tuser: [2:0] command
    input  logic [cctc_pkg::CMD_W-1:0]    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // tdata: [7:0] read_data, [8] tc_pulse, [9] int_pending,
    //        [17:10] int_vector, [21:18] zero_flags, rest zero
    output logic [cctc_pkg::M_DATA_W-1:0] m_axis_tdata
);
    import cctc_pkg::*;

    // Channel state
    logic [7:0]        r_cw   [NUM_CH];
    logic [7:0]        r_tcon [NUM_CH];
    logic [7:0]        r_cnt  [NUM_CH];
    logic [7:0]        n_cw   [NUM_CH];
    logic [7:0]        n_tcon [NUM_CH];
    logic [7:0]        n_cnt  [NUM_CH];
    logic              r_trig0, n_trig0;
    logic [NUM_CH-1:0] r_zc, n_zc;
    logic [NUM_CH-1:0] r_pend, n_pend;
    logic [7:0]        r_vb, n_vb;

    // Output register and skid stage
    logic    r_m_valid, r_sk_valid;
    t_result r_m_data, r_sk_data;
    t_result w_res;

    // Decoded input word
    t_cmd       w_cmd;
    logic [1:0] w_ch;
    logic [7:0] w_wdata;
    logic       w_acc;
    logic       w_accept;

    logic [NUM_CH-1:0] w_fire;   // rising edge reaches counter
    logic [NUM_CH-1:0] w_hit;    // counter reaches zero on that edge
    logic [CH_W-1:0]   w_low;
    logic              w_any;

    assign w_cmd    = t_cmd'(s_axis_tuser);
    assign w_ch     = s_axis_tdata[1:0];
    assign w_wdata  = s_axis_tdata[9:2];
    assign w_acc    = s_axis_tdata[10];
    assign w_accept = s_axis_tvalid && s_axis_tready;

    // Cascade chain: 0 -> 1 -> 2; channel 3 on frame tick.
    // Channels 1..3 always see their trigger low before a pulse.
    always_comb begin
        w_fire[0] = w_accept && (w_cmd == CMD_RISE) && !r_trig0
                    && ((r_cw[0] & CW_RESET) == '0);
        w_hit[0]  = w_fire[0] && (r_cnt[0] == 8'd1);
        w_fire[1] = w_hit[0] && ((r_cw[1] & CW_RESET) == '0);
        w_hit[1]  = w_fire[1] && (r_cnt[1] == 8'd1);
        w_fire[2] = w_hit[1] && ((r_cw[2] & CW_RESET) == '0);
        w_hit[2]  = w_fire[2] && (r_cnt[2] == 8'd1);
        w_fire[3] = w_accept && (w_cmd == CMD_TICK) && ((r_cw[3] & CW_RESET) == '0);
        w_hit[3]  = w_fire[3] && (r_cnt[3] == 8'd1);
    end

    // Next state
    always_comb begin
        n_cw    = r_cw;
        n_tcon  = r_tcon;
        n_cnt   = r_cnt;
        n_trig0 = r_trig0;
        n_zc    = r_zc;
        n_pend  = r_pend;
        n_vb    = r_vb;

        if (w_accept) begin
            case (w_cmd)
                CMD_WRITE: begin
                    if ((r_cw[w_ch] & CW_TC_NEXT) != '0) begin
                        // time constant follows a control word that asked for it
                        n_cw[w_ch]   = r_cw[w_ch] & ~(CW_TC_NEXT | CW_RESET);
                        n_tcon[w_ch] = w_wdata;
                        n_cnt[w_ch]  = w_wdata;
                        n_zc[w_ch]   = 1'b0;
                        n_pend[w_ch] = 1'b0;
                    end else if ((w_wdata & CW_CONTROL) != '0) begin
                        n_cw[w_ch] = w_wdata;
                        if ((w_wdata & CW_RESET) != '0) begin
                            n_zc[w_ch]   = 1'b0;
                            n_pend[w_ch] = 1'b0;
                        end
                    end else begin
                        n_vb = w_wdata;
                    end
                end
                CMD_RISE: n_trig0 = 1'b1;
                CMD_FALL: n_trig0 = 1'b0;
                CMD_ACK: begin
                    // clear lowest pending bit when vector taken
                    if (w_acc) begin
                        n_pend = r_pend & ~(r_pend & (~r_pend + 4'd1));
                    end
                end
                default: ;
            endcase
        end

        // Counting; fire bits are exclusive with write/ack
        for (int i = 0; i < NUM_CH; i++) begin
            if (w_fire[i]) begin
                n_zc[i]  = w_hit[i];
                n_cnt[i] = w_hit[i] ? r_tcon[i] : r_cnt[i] - 8'd1;
                if (w_hit[i] && ((r_cw[i] & CW_INT_EN) != '0)) begin
                    n_pend[i] = 1'b1;
                end
            end
        end
    end

    // Lowest pending channel after the event
    always_comb begin
        w_low = '0;
        for (int i = NUM_CH - 1; i >= 0; i--) begin
            if (n_pend[i]) begin
                w_low = CH_W'(i);
            end
        end
        w_any = |n_pend;
    end

    // Result word; vector uses the base as left by this event
    always_comb begin
        w_res.read_data   = (w_cmd == CMD_READ) ? r_cnt[w_ch] : 8'd0;
        w_res.tc_pulse    = (w_cmd == CMD_RISE) && !r_zc[2] && n_zc[2];
        w_res.int_pending = w_any;
        w_res.int_vector  = w_any ? ((n_vb & VEC_MASK) | {5'd0, w_low, 1'b0}) : 8'd0;
        w_res.zero_flags  = n_zc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CH; i++) begin
                r_cw[i]   <= CW_RESET;
                r_tcon[i] <= '0;
                r_cnt[i]  <= '0;
            end
            r_trig0 <= 1'b0;
            r_zc    <= '0;
            r_pend  <= '0;
            r_vb    <= '0;
        end else begin
            r_cw    <= n_cw;
            r_tcon  <= n_tcon;
            r_cnt   <= n_cnt;
            r_trig0 <= n_trig0;
            r_zc    <= n_zc;
            r_pend  <= n_pend;
            r_vb    <= n_vb;
        end
    end

    // Output register with skid: input is held off only while the skid is full
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid  <= 1'b0;
            r_sk_valid <= 1'b0;
        end else if (!r_m_valid || m_axis_tready) begin
            if (r_sk_valid) begin
                r_m_valid  <= 1'b1;
                r_sk_valid <= 1'b0;
            end else begin
                r_m_valid <= w_accept;
            end
        end else if (w_accept) begin
            r_sk_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_m_valid || m_axis_tready) begin
            r_m_data <= r_sk_valid ? r_sk_data : w_res;
        end else if (w_accept) begin
            r_sk_data <= w_res;
        end
    end

    assign s_axis_tready = !r_sk_valid;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {2'b00, r_m_data};

endmodule

>>> design/cctc_checker.sv
// Port-level assertions for the counter block, bound to the top level.
module cctc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [15:0] s_axis_tdata,
    input logic [2:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    // stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    // input is only held off while a word waits on the output
    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with empty output");

    // no vector without a pending interrupt
    a_vec_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[9] |-> m_axis_tdata[17:10] == 8'd0)
        else $error("vector nonzero with nothing pending");

    // vector bit 0 is never set
    a_vec_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !m_axis_tdata[10])
        else $error("odd interrupt vector");

    // terminal count implies channel 2 zero flag
    a_tc_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[8] |-> m_axis_tdata[20])
        else $error("tc pulse without channel 2 zero flag");

endmodule

bind cascaded_ctc_byte_counter cctc_checker u_cctc_checker (.*);

>>> verif/tb_cascaded_ctc_byte_counter.sv
// Testbench for the cascaded counter/timer byte counter: self-checking stream driver and monitor.
`timescale 1ns / 100ps

module tb_cascaded_ctc_byte_counter;
    import cctc_pkg::*;

    // Command codes beyond the package enum; the block must treat them as no-ops.
    localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

    localparam int N_DIRECTED  = 25;
    localparam int N_RANDOM    = 700;
    localparam int HOLD_AT     = 300;   // words sent before the long sink stall
    localparam int HOLD_CYCLES = 150;
    localparam int STALL_LIMIT = 2000;  // cycles with no word moving on either side

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [1:0]       ch;
        logic [7:0]       data;
        logic             acc;
    } t_event;

    // DUT ports; every input starts at a known value
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // tdata: [1:0] channel, [9:2] write_data, [10] accepted, rest zero
    logic [S_DATA_W-1:0]   s_axis_tdata  = '0;
    // tuser: [2:0] command
    logic [CMD_W-1:0]      s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // tdata: [7:0] read_data, [8] tc_pulse, [9] int_pending,
    //        [17:10] int_vector, [21:18] zero_flags, rest zero
    logic [M_DATA_W-1:0]   m_axis_tdata;

    cascaded_ctc_byte_counter u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the four channels
    // ------------------------------------------------------------------
    logic [7:0] ctl_word  [NUM_CH];
    logic [7:0] time_const[NUM_CH];
    logic [7:0] count     [NUM_CH];
    bit         trig_lvl  [NUM_CH];
    bit         zero_hit  [NUM_CH];
    bit         irq_pend  [NUM_CH];
    logic [7:0] vec_base;

    t_event  pend_q[$];     // words still to be offered
    t_result status_q[$];   // status words the block owes us, oldest first
    bit      tc_wait[NUM_CH];   // stimulus-side view: next write to channel is a time constant

    int  n_total;
    int  n_sent;
    int  n_recv;
    int  n_bad;
    int  n_tc;
    int  n_irq;
    int  n_zero;
    bit  long_hold = 1'b0;

    task automatic ctc_clear();
        for (int i = 0; i < NUM_CH; i++) begin
            ctl_word[i]   = CW_RESET;
            time_const[i] = 8'h00;
            count[i]      = 8'h00;
            trig_lvl[i]   = 1'b0;
            zero_hit[i]   = 1'b0;
            irq_pend[i]   = 1'b0;
        end
        vec_base = 8'h00;
    endtask

    // Drive one channel's trigger to a level; returns 1 when the count hit zero.
    function automatic bit trig_drive(int ch, bit level);
        bit hit;
        hit = 1'b0;
        if ((ctl_word[ch] & CW_RESET) == 8'h00 && level && !trig_lvl[ch]) begin
            count[ch]    = count[ch] - 8'd1;
            zero_hit[ch] = (count[ch] == 8'h00);
            if (zero_hit[ch]) begin
                count[ch] = time_const[ch];
                if ((ctl_word[ch] & CW_INT_EN) != 8'h00)
                    irq_pend[ch] = 1'b1;
                hit = 1'b1;
            end
        end
        trig_lvl[ch] = level;
        return hit;
    endfunction

    // One full high/low pulse, as the cascade and the frame tick deliver.
    function automatic bit trig_pulse(int ch);
        bit hit;
        hit = trig_drive(ch, 1'b1);
        void'(trig_drive(ch, 1'b0));
        return hit;
    endfunction

    function automatic int lowest_irq();
        for (int i = 0; i < NUM_CH; i++)
            if (irq_pend[i])
                return i;
        return -1;
    endfunction

    // Apply one event and return the status word it should produce.
    function automatic t_result ctc_event_status(t_event ev);
        t_result r;
        bit      zc2_was;
        int      low;
        r = '0;
        case (ev.cmd)
            CMD_READ: r.read_data = count[ev.ch];
            CMD_WRITE: begin
                if ((ctl_word[ev.ch] & CW_TC_NEXT) != 8'h00) begin
                    // time constant: loads counter too and re-arms the channel
                    ctl_word[ev.ch]   = ctl_word[ev.ch] & ~(CW_TC_NEXT | CW_RESET);
                    time_const[ev.ch] = ev.data;
                    count[ev.ch]      = ev.data;
                    zero_hit[ev.ch]   = 1'b0;
                    irq_pend[ev.ch]   = 1'b0;
                end else if ((ev.data & CW_CONTROL) != 8'h00) begin
                    ctl_word[ev.ch] = ev.data;
                    if ((ev.data & CW_RESET) != 8'h00) begin
                        zero_hit[ev.ch] = 1'b0;
                        irq_pend[ev.ch] = 1'b0;
                    end
                end else begin
                    vec_base = ev.data;
                end
            end
            CMD_RISE: begin
                zc2_was = zero_hit[2];
                // cascade: 0 -> 1 -> 2, each only when the one below hit zero now
                if (trig_drive(0, 1'b1))
                    if (trig_pulse(1))
                        void'(trig_pulse(2));
                r.tc_pulse = !zc2_was && zero_hit[2];
            end
            CMD_FALL: void'(trig_drive(0, 1'b0));
            CMD_TICK: void'(trig_pulse(3));
            CMD_ACK: begin
                low = lowest_irq();
                if (low >= 0 && ev.acc)
                    irq_pend[low] = 1'b0;
            end
            default: ;
        endcase
        low = lowest_irq();
        if (low >= 0) begin
            r.int_pending = 1'b1;
            r.int_vector  = (vec_base & VEC_MASK) | 8'(low << 1);
        end
        for (int i = 0; i < NUM_CH; i++)
            r.zero_flags[i] = zero_hit[i];
        return r;
    endfunction

    // Queue one event, tracking which channels expect a time constant next.
    task automatic push_ev(logic [CMD_W-1:0] cmd, int ch, logic [7:0] data, bit acc);
        t_event ev;
        ev.cmd  = cmd;
        ev.ch   = 2'(ch);
        ev.data = data;
        ev.acc  = acc;
        pend_q.push_back(ev);
        if (cmd == CMD_WRITE) begin
            if (tc_wait[ch])
                tc_wait[ch] = 1'b0;
            else if (data[0])
                tc_wait[ch] = data[2];
        end
    endtask

    task automatic note_bad(t_result want, logic [M_DATA_W-1:0] raw);
        t_result got;
        got = t_result'(raw[$bits(t_result)-1:0]);
        n_bad++;
        if (n_bad <= 10)
            $display("word %0d mismatch: exp rd=%h tc=%b ip=%b vec=%h zf=%h | got rd=%h tc=%b ip=%b vec=%h zf=%h pad=%b",
                     n_recv, want.read_data, want.tc_pulse, want.int_pending, want.int_vector,
                     want.zero_flags, got.read_data, got.tc_pulse, got.int_pending,
                     got.int_vector, got.zero_flags, raw[M_DATA_W-1:$bits(t_result)]);
    endtask

    // ------------------------------------------------------------------
    // Driver: offers queued words; accepted words go through the predictor
    // ------------------------------------------------------------------
    t_event cur_ev;
    int     gap_left;
    bit     drv_burst;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            gap_left  = 0;
            drv_burst = 1'b0;
            ctc_clear();
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                status_q.push_back(ctc_event_status(cur_ev));
                n_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                // during the long sink stall keep offering back to back
                if (gap_left != 0 && !long_hold) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (pend_q.size() != 0) begin
                    cur_ev = pend_q.pop_front();
                    s_axis_tdata  <= {5'b0, cur_ev.acc, cur_ev.data, cur_ev.ch};
                    s_axis_tuser  <= cur_ev.cmd;
                    s_axis_tvalid <= 1'b1;
                    if ($urandom_range(0, 39) == 0)
                        drv_burst = !drv_burst;
                    gap_left = drv_burst ? 0 : $urandom_range(0, 9);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random sink stalls, every status word checked in order
    // ------------------------------------------------------------------
    int stall_left;
    int stall_nxt;
    bit mon_burst;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
            mon_burst  = 1'b0;
        end else begin
            stall_nxt = (stall_left > 0) ? stall_left - 1 : 0;
            if (m_axis_tvalid && m_axis_tready) begin
                n_recv++;
                if (status_q.size() == 0) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("word %0d unexpected: %h with nothing outstanding",
                                 n_recv, m_axis_tdata);
                end else begin
                    if (m_axis_tdata !== {{(M_DATA_W - $bits(t_result)){1'b0}}, status_q[0]})
                        note_bad(status_q[0], m_axis_tdata);
                    if (status_q[0].tc_pulse)
                        n_tc++;
                    if (status_q[0].int_pending)
                        n_irq++;
                    if (status_q[0].zero_flags != 4'h0)
                        n_zero++;
                    void'(status_q.pop_front());
                end
                if ($urandom_range(0, 39) == 0)
                    mon_burst = !mon_burst;
                stall_nxt = mon_burst ? 0 : $urandom_range(0, 9);
            end
            stall_left = stall_nxt;
            m_axis_tready <= (stall_nxt == 0) && !long_hold;
        end
    end

    // Long sink stall: the two output slots fill and tready must drop upstream.
    initial begin
        while (n_sent < HOLD_AT)
            @(posedge i_clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        long_hold <= 1'b0;
    end

    // Watchdog: nothing moving on either side for too long means a hang.
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == STALL_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        int r;
        int c;
        for (int i = 0; i < NUM_CH; i++)
            tc_wait[i] = 1'b0;

        // Directed: counters read at reset, vector base, channel setup with
        // cascade 0->1->2, terminal count, rise while already high, frame tick,
        // refused and taken acknowledges, spare commands, reset-bit control word.
        push_ev(CMD_READ,   0, 8'h00, 1'b0);
        push_ev(CMD_READ,   3, 8'hff, 1'b1);
        push_ev(CMD_WRITE,  0, 8'hfe, 1'b0);      // vector base
        push_ev(CMD_WRITE,  0, 8'h85, 1'b0);      // int enable, time constant follows
        push_ev(CMD_WRITE,  0, 8'h01, 1'b0);
        push_ev(CMD_WRITE,  1, 8'h85, 1'b0);
        push_ev(CMD_WRITE,  1, 8'h01, 1'b0);
        push_ev(CMD_WRITE,  2, 8'hc5, 1'b0);
        push_ev(CMD_WRITE,  2, 8'h02, 1'b0);
        push_ev(CMD_WRITE,  3, 8'h87, 1'b1);      // reset bit cleared by the constant
        push_ev(CMD_WRITE,  3, 8'hff, 1'b1);
        push_ev(CMD_RISE,   0, 8'h00, 1'b0);      // 0 and 1 hit zero, 2 counts down
        push_ev(CMD_RISE,   1, 8'h55, 1'b1);      // already high: no count
        push_ev(CMD_FALL,   2, 8'haa, 1'b0);
        push_ev(CMD_RISE,   3, 8'hff, 1'b1);      // channel 2 terminal count
        push_ev(CMD_FALL,   0, 8'h00, 1'b0);
        push_ev(CMD_TICK,   0, 8'h00, 1'b0);
        push_ev(CMD_ACK,    0, 8'h00, 1'b0);      // refused: stays pending
        push_ev(CMD_ACK,    0, 8'h00, 1'b1);
        push_ev(CMD_SPARE6, 3, 8'hff, 1'b1);
        push_ev(CMD_SPARE7, 1, 8'h5a, 1'b0);
        push_ev(CMD_READ,   2, 8'h00, 1'b0);
        push_ev(CMD_WRITE,  1, 8'h03, 1'b0);      // reset bit clears flags
        push_ev(CMD_ACK,    0, 8'h00, 1'b1);
        push_ev(CMD_WRITE,  2, 8'h00, 1'b1);      // vector base back to zero

        // Random: channel setups plus trigger traffic, which is the largest share, so the
        // cascade and interrupts fire often; the rest is reads, acks and noise.
        while (pend_q.size() < N_DIRECTED + N_RANDOM) begin
            r = $urandom_range(0, 99);
            c = $urandom_range(0, NUM_CH - 1);
            if (r < 8) begin
                if (!tc_wait[c])
                    push_ev(CMD_WRITE, c, CW_TC_NEXT | CW_CONTROL | (8'($urandom) & 8'hf8)
                            | ($urandom_range(0, 1) ? CW_RESET : 8'h00), 1'($urandom));
                push_ev(CMD_WRITE, c, ($urandom_range(0, 9) == 0) ? 8'($urandom)
                        : 8'($urandom_range(1, 4)), 1'($urandom));
            end else if (r < 12) begin
                if (!tc_wait[c])
                    push_ev(CMD_WRITE, c, 8'($urandom) & ~CW_CONTROL, 1'($urandom));
            end else if (r < 50) begin
                push_ev(CMD_RISE, c, 8'($urandom), 1'($urandom));
                if ($urandom_range(0, 9) == 0)
                    push_ev(CMD_RISE, $urandom_range(0, 3), 8'($urandom), 1'($urandom));
                if ($urandom_range(0, 9) != 0)
                    push_ev(CMD_FALL, $urandom_range(0, 3), 8'($urandom), 1'($urandom));
            end else if (r < 60) begin
                push_ev(CMD_TICK, c, 8'($urandom), 1'($urandom));
            end else if (r < 70) begin
                push_ev(CMD_READ, c, 8'($urandom), 1'($urandom));
            end else if (r < 80) begin
                push_ev(CMD_ACK, c, 8'($urandom), $urandom_range(0, 3) != 0);
            end else if (r < 86) begin
                push_ev(CMD_WRITE, c, 8'($urandom), 1'($urandom));
            end else begin
                push_ev(3'($urandom_range(0, 7)), c, 8'($urandom), 1'($urandom));
            end
        end
        n_total = pend_q.size();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_sent < n_total)
            @(posedge i_clk);
        while (status_q.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);   // catch any stray trailing word

        $display("%0d event words checked: %0d terminal-count pulses, %0d with irq pending,",
                 n_recv, n_tc, n_irq);
        $display("%0d with a zero-count flag set, sink held off %0d cycles once, %0d mismatches",
                 n_zero, HOLD_CYCLES, n_bad);
        if (n_bad == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
